// ===== src/chs_pkg.sv =====
// Shared types, constants and segment decode functions for the cooling health scorer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package chs_pkg;

    // Dimension count and lane indexes.
    localparam int NUM_DIM  = 6;
    localparam int DIM_TEMP = 0;
    localparam int DIM_FLOW = 1;
    localparam int DIM_PRES = 2;
    localparam int DIM_VIB  = 3;
    localparam int DIM_WATR = 4;
    localparam int DIM_EFF  = 5;

    // Cycles from the edge that takes a request to the result strobe.
    localparam int PIPE_LATENCY = 11;

    typedef logic [9:0] t_score;
    typedef logic [NUM_DIM-1:0][9:0] t_score_vec;
    typedef logic [6:0] t_weight;
    typedef logic [NUM_DIM-1:0][6:0] t_weight_vec;

    localparam logic [9:0] SCORE_MAX = 10'd1000;

    // Percent weights after reset, lane 0 in the low bits.
    localparam t_weight_vec WEIGHT_RESET = {7'd15, 7'd10, 7'd15, 7'd15, 7'd20, 7'd25};

    // Health level codes.
    localparam logic [2:0] LEVEL_EXCELLENT = 3'd0;
    localparam logic [2:0] LEVEL_GOOD      = 3'd1;
    localparam logic [2:0] LEVEL_FAIR      = 3'd2;
    localparam logic [2:0] LEVEL_POOR      = 3'd3;
    localparam logic [2:0] LEVEL_DANGER    = 3'd4;

    // Segment slopes as reciprocal constants: floor(a*x/c) = (x*K) >> SEG_SHIFT,
    // with K = ceil(a * 2^SEG_SHIFT / c). Exact for x below 2^11.
    localparam int SEG_SHIFT = 30;
    localparam logic [63:0] SEG_ONE = 64'd1 << SEG_SHIFT;

    localparam logic [33:0] K_1     = 34'(SEG_ONE);
    localparam logic [33:0] K_2     = 34'(2 * SEG_ONE);
    localparam logic [33:0] K_3     = 34'(3 * SEG_ONE);
    localparam logic [33:0] K_4     = 34'(4 * SEG_ONE);
    localparam logic [33:0] K_6     = 34'(6 * SEG_ONE);
    localparam logic [33:0] K_4_3   = 34'((4 * SEG_ONE + 2) / 3);
    localparam logic [33:0] K_4_17  = 34'((4 * SEG_ONE + 16) / 17);
    localparam logic [33:0] K_20_3  = 34'((20 * SEG_ONE + 2) / 3);
    localparam logic [33:0] K_3_5   = 34'((3 * SEG_ONE + 4) / 5);
    localparam logic [33:0] K_3_10  = 34'((3 * SEG_ONE + 9) / 10);
    localparam logic [33:0] K_1_10  = 34'((SEG_ONE + 9) / 10);
    localparam logic [33:0] K_3_2   = 34'((3 * SEG_ONE + 1) / 2);
    localparam logic [33:0] K_2_5   = 34'((2 * SEG_ONE + 4) / 5);
    localparam logic [33:0] K_4_7   = 34'((4 * SEG_ONE + 6) / 7);

    // Pump blend divide by 50: numerator below 2^16.
    localparam int BLEND_SHIFT = 22;
    localparam logic [16:0] BLEND_MULT = 17'(((64'd1 << BLEND_SHIFT) + 49) / 50);

    // Weighted total divide by 100: sum below 2^20.
    localparam int TOTAL_SHIFT = 27;
    localparam logic [20:0] TOTAL_MULT = 21'(((64'd1 << TOTAL_SHIFT) + 99) / 100);

    // One decoded segment: score = base + ((x * k) >> SEG_SHIFT).
    typedef struct packed {
        logic [10:0] x;
        logic [33:0] k;
        logic [9:0]  base;
    } t_seg;

    // Smaller is better, breakpoints p < g < w < b.
    function automatic t_seg seg_down(input logic signed [16:0] v, input int p, input int g,
                                      input int w, input int b, input logic [33:0] k1,
                                      input logic [33:0] k2, input logic [33:0] k3,
                                      input logic [33:0] k4);
        t_seg s;
        s.x    = '0;
        s.k    = '0;
        s.base = 10'd0;
        if (v <= p) begin
            s.base = SCORE_MAX;
        end else if (v <= g) begin
            s.base = 10'd800;
            s.x    = 11'(g - v);
            s.k    = k1;
        end else if (v <= w) begin
            s.base = 10'd500;
            s.x    = 11'(w - v);
            s.k    = k2;
        end else if (v <= b) begin
            s.base = 10'd200;
            s.x    = 11'(b - v);
            s.k    = k3;
        end else if (v < 2 * b) begin
            s.x    = 11'(2 * b - v);
            s.k    = k4;
        end
        return s;
    endfunction

    // Larger is better, breakpoints p > g > w > b.
    function automatic t_seg seg_up(input logic signed [16:0] v, input int p, input int g,
                                    input int w, input int b, input logic [33:0] k1,
                                    input logic [33:0] k2, input logic [33:0] k3,
                                    input logic [33:0] k4);
        t_seg s;
        s.x    = '0;
        s.k    = '0;
        s.base = 10'd0;
        if (v >= p) begin
            s.base = SCORE_MAX;
        end else if (v >= g) begin
            s.base = 10'd800;
            s.x    = 11'(v - g);
            s.k    = k1;
        end else if (v >= w) begin
            s.base = 10'd500;
            s.x    = 11'(v - w);
            s.k    = k2;
        end else if (v >= b) begin
            s.base = 10'd200;
            s.x    = 11'(v - b);
            s.k    = k3;
        end else if (v > 0) begin
            s.x    = 11'(v);
            s.k    = k4;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/chs_score.sv =====
// Per-dimension score lanes: segment decode, slope multiply, base add (three stages).
// Depends on chs_pkg for the segment functions and slope constants.
`default_nettype none

module chs_score
    import chs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [11:0] i_cpu_temperature,
    input  wire logic signed [11:0] i_water_temperature,
    input  wire logic [11:0]        i_flow_rate,
    input  wire logic [9:0]         i_loop_pressure,
    input  wire logic [13:0]        i_vibration_level,
    input  wire logic [15:0]        i_dissolved_solids,
    input  wire logic [6:0]         i_pump_duty,
    output logic                    o_valid,
    output t_score_vec              o_scores,
    output logic [6:0]              o_pump_duty
);

    logic [9:0]                  pres_dev;
    logic signed [12:0]          temp_gap;
    logic [11:0]                 gap_pos;
    t_seg [NUM_DIM-1:0]          n_seg;
    t_seg [NUM_DIM-1:0]          r_seg;
    logic [NUM_DIM-1:0][44:0]    r_prod;
    logic [NUM_DIM-1:0][9:0]     r_base;
    logic                        r_valid1;
    logic                        r_valid2;
    logic                        r_valid3;
    logic [6:0]                  r_duty1;
    logic [6:0]                  r_duty2;
    logic [6:0]                  r_duty3;
    t_score_vec                  r_scores;

    // Derived measures: pressure distance from 200 kPa, CPU-to-water gap clamped at zero.
    always_comb begin
        pres_dev = (i_loop_pressure >= 10'd200) ? (i_loop_pressure - 10'd200)
                                                : (10'd200 - i_loop_pressure);
        temp_gap = 13'(i_cpu_temperature) - 13'(i_water_temperature);
        gap_pos  = temp_gap[12] ? 12'd0 : temp_gap[11:0];
    end

    // Segment decode for each dimension.
    always_comb begin
        n_seg[DIM_TEMP] = seg_down(17'(i_cpu_temperature), 450, 600, 750, 850,
                                   K_4_3, K_2, K_3, K_4_17);
        n_seg[DIM_FLOW] = seg_up($signed({5'b0, i_flow_rate}), 400, 300, 150, 50,
                                 K_2, K_2, K_3, K_4);
        n_seg[DIM_PRES] = seg_down($signed({7'b0, pres_dev}), 20, 50, 100, 150,
                                   K_20_3, K_6, K_6, K_4_3);
        n_seg[DIM_VIB]  = seg_down($signed({3'b0, i_vibration_level}), 300, 500, 1000, 2000,
                                   K_1, K_3_5, K_3_10, K_1_10);
        n_seg[DIM_WATR] = seg_down($signed({1'b0, i_dissolved_solids}), 50, 100, 300, 500,
                                   K_4, K_3_2, K_3_2, K_2_5);
        n_seg[DIM_EFF]  = seg_down($signed({5'b0, gap_pos}), 100, 150, 250, 350,
                                   K_4, K_3, K_3, K_4_7);
    end

    // Valid bits of the three lane stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    // Lane datapath: decode register, slope product, base plus quotient.
    always_ff @(posedge i_clk) begin
        r_seg   <= n_seg;
        r_duty1 <= i_pump_duty;
        r_duty2 <= r_duty1;
        r_duty3 <= r_duty2;
        for (int i = 0; i < NUM_DIM; i++) begin
            r_prod[i]   <= 45'(r_seg[i].x) * 45'(r_seg[i].k);
            r_base[i]   <= r_seg[i].base;
            r_scores[i] <= r_base[i] + r_prod[i][SEG_SHIFT+9:SEG_SHIFT];
        end
    end

    assign o_valid     = r_valid3;
    assign o_scores    = r_scores;
    assign o_pump_duty = r_duty3;

endmodule

`default_nettype wire

// ===== src/chs_blend.sv =====
// Pump duty blend of the efficiency score toward full score (three stages).
// Depends on chs_pkg for the score types and the divide-by-50 constant.
`default_nettype none

module chs_blend
    import chs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_score_vec i_scores,
    input  wire logic [6:0] i_pump_duty,
    output logic            o_valid,
    output t_score_vec      o_scores
);

    logic [15:0] n_num;
    logic [15:0] r_num;
    logic [32:0] r_bprod;
    logic        r_blend1;
    logic        r_blend2;
    logic        r_valid1;
    logic        r_valid2;
    logic        r_valid3;
    t_score_vec  r_sc1;
    t_score_vec  r_sc2;
    t_score_vec  n_sc3;
    t_score_vec  r_sc3;

    // Blend numerator: score * duty + 1000 * (50 - duty), meaningful for duty below 50.
    always_comb begin
        n_num = 16'(i_scores[DIM_EFF]) * 16'(i_pump_duty)
              + 16'd1000 * (16'd50 - 16'(i_pump_duty));
    end

    // The blended efficiency score replaces the plain one when the pump runs slow.
    always_comb begin
        n_sc3 = r_sc2;
        if (r_blend2) begin
            n_sc3[DIM_EFF] = r_bprod[BLEND_SHIFT+9:BLEND_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    // Numerator, reciprocal product, then select blended or plain score.
    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_blend1 <= (i_pump_duty < 7'd50);
        r_sc1    <= i_scores;
        r_bprod  <= 33'(r_num) * 33'(BLEND_MULT);
        r_blend2 <= r_blend1;
        r_sc2    <= r_sc1;
        r_sc3    <= n_sc3;
    end

    assign o_valid  = r_valid3;
    assign o_scores = r_sc3;

endmodule

`default_nettype wire

// ===== src/chs_total.sv =====
// Weighted total, divide by 100, clamp and health level (five stages).
// Depends on chs_pkg for the score and weight types, level codes and constants.
`default_nettype none

module chs_total
    import chs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_score_vec  i_scores,
    input  wire t_weight_vec i_weights,
    output logic             o_valid,
    output t_score_vec       o_scores,
    output logic [9:0]       o_overall_score,
    output logic [2:0]       o_health_level
);

    logic [NUM_DIM-1:0][16:0] r_wprod;
    logic [18:0]              r_psum_lo;
    logic [18:0]              r_psum_hi;
    logic [19:0]              r_sum;
    logic [40:0]              r_qprod;
    logic [12:0]              quot;
    logic [9:0]               n_total;
    logic [2:0]               n_level;
    logic [4:0]               r_valid;
    t_score_vec [3:0]         r_sc;
    t_score_vec               r_sc_out;
    logic [9:0]               r_total;
    logic [2:0]               r_level;

    // Quotient of the weighted sum by 100, clamped, and its level.
    always_comb begin
        quot    = r_qprod[TOTAL_SHIFT+12:TOTAL_SHIFT];
        n_total = (quot > 13'(SCORE_MAX)) ? SCORE_MAX : quot[9:0];
        if (n_total >= 10'd900) begin
            n_level = LEVEL_EXCELLENT;
        end else if (n_total >= 10'd700) begin
            n_level = LEVEL_GOOD;
        end else if (n_total >= 10'd500) begin
            n_level = LEVEL_FAIR;
        end else if (n_total >= 10'd300) begin
            n_level = LEVEL_POOR;
        end else begin
            n_level = LEVEL_DANGER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    // Weight products, partial sums, full sum, reciprocal product, output register.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_DIM; i++) begin
            r_wprod[i] <= 17'(i_scores[i]) * 17'(i_weights[i]);
        end
        r_psum_lo <= 19'(r_wprod[0]) + 19'(r_wprod[1]) + 19'(r_wprod[2]);
        r_psum_hi <= 19'(r_wprod[3]) + 19'(r_wprod[4]) + 19'(r_wprod[5]);
        r_sum     <= 20'(r_psum_lo) + 20'(r_psum_hi);
        r_qprod   <= 41'(r_sum) * 41'(TOTAL_MULT);
        r_sc      <= {r_sc[2:0], i_scores};
        r_sc_out  <= r_sc[3];
        r_total   <= n_total;
        r_level   <= n_level;
    end

    assign o_valid         = r_valid[4];
    assign o_scores        = r_sc_out;
    assign o_overall_score = r_total;
    assign o_health_level  = r_level;

endmodule

`default_nettype wire

// ===== src/cooling_health_scorer_core.sv =====
// Top level of the cooling loop health scorer: input register, weight registers, pipeline.
// Depends on chs_pkg, chs_score, chs_blend and chs_total.
//
// Usage:
//   A request (one sensor sample) is taken at a rising edge where i_start is high and
//   o_busy is low. o_busy is low whenever reset is released, so a request can be
//   issued every cycle; the pipeline has no loop and needs no gap between samples.
//   Each request yields one result: o_valid is high for exactly one cycle, with the six
//   dimension scores, the weighted total and the health level. Results leave in request
//   order. The pipeline chains lane decode, slope multiply, pump blend divide, weighting
//   and divide by 100. The receiver cannot hold results off, so nothing ever waits
//   inside the block. Percent weights are written through i_cfg_we / i_cfg_index /
//   i_cfg_data, one register per cycle; indexes above 5 are ignored. The user must
//   write them only while no request is in flight; the block does not enforce this.
//   Reset (i_rst_n low at a clock edge) drops all requests in flight and restores
//   the default weights 25/20/15/15/10/15; o_busy is high while reset is held.
`default_nettype none

module cooling_health_scorer_core
    import chs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [11:0] i_cpu_temperature,
    input  wire logic signed [11:0] i_water_temperature,
    input  wire logic [11:0]        i_flow_rate,
    input  wire logic [9:0]         i_loop_pressure,
    input  wire logic [13:0]        i_vibration_level,
    input  wire logic [15:0]        i_dissolved_solids,
    input  wire logic [6:0]         i_pump_duty,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data,
    output logic                    o_valid,
    output logic [9:0]              o_temperature_score,
    output logic [9:0]              o_flow_score,
    output logic [9:0]              o_pressure_score,
    output logic [9:0]              o_vibration_score,
    output logic [9:0]              o_water_score,
    output logic [9:0]              o_efficiency_score,
    output logic [9:0]              o_overall_score,
    output logic [2:0]              o_health_level
);

    logic               r_in_valid;
    logic signed [11:0] r_cpu;
    logic signed [11:0] r_water;
    logic [11:0]        r_flow;
    logic [9:0]         r_pres;
    logic [13:0]        r_vib;
    logic [15:0]        r_tds;
    logic [6:0]         r_duty;
    t_weight_vec        r_weight;
    logic               sc_valid;
    t_score_vec         sc_scores;
    logic [6:0]         sc_duty;
    logic               bl_valid;
    t_score_vec         bl_scores;
    t_score_vec         out_scores;

    assign o_busy = !i_rst_n;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cpu   <= i_cpu_temperature;
        r_water <= i_water_temperature;
        r_flow  <= i_flow_rate;
        r_pres  <= i_loop_pressure;
        r_vib   <= i_vibration_level;
        r_tds   <= i_dissolved_solids;
        r_duty  <= i_pump_duty;
    end

    // Weight registers; writes beyond the last weight are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we && (i_cfg_index < 3'(NUM_DIM))) begin
            r_weight[i_cfg_index] <= i_cfg_data;
        end
    end

    chs_score u_score (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (r_in_valid),
        .i_cpu_temperature   (r_cpu),
        .i_water_temperature (r_water),
        .i_flow_rate         (r_flow),
        .i_loop_pressure     (r_pres),
        .i_vibration_level   (r_vib),
        .i_dissolved_solids  (r_tds),
        .i_pump_duty         (r_duty),
        .o_valid             (sc_valid),
        .o_scores            (sc_scores),
        .o_pump_duty         (sc_duty)
    );

    chs_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sc_valid),
        .i_scores    (sc_scores),
        .i_pump_duty (sc_duty),
        .o_valid     (bl_valid),
        .o_scores    (bl_scores)
    );

    chs_total u_total (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (bl_valid),
        .i_scores        (bl_scores),
        .i_weights       (r_weight),
        .o_valid         (o_valid),
        .o_scores        (out_scores),
        .o_overall_score (o_overall_score),
        .o_health_level  (o_health_level)
    );

    assign o_temperature_score = out_scores[DIM_TEMP];
    assign o_flow_score        = out_scores[DIM_FLOW];
    assign o_pressure_score    = out_scores[DIM_PRES];
    assign o_vibration_score   = out_scores[DIM_VIB];
    assign o_water_score       = out_scores[DIM_WATR];
    assign o_efficiency_score  = out_scores[DIM_EFF];

endmodule

`default_nettype wire

// ===== src/chs_checker.sv =====
// Port-level checker for the cooling health scorer, bound to the top level.
// Depends on chs_pkg for the latency and level codes.
`default_nettype none

module chs_checker
    import chs_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid,
    input wire logic [9:0]  o_temperature_score,
    input wire logic [9:0]  o_flow_score,
    input wire logic [9:0]  o_pressure_score,
    input wire logic [9:0]  o_vibration_score,
    input wire logic [9:0]  o_water_score,
    input wire logic [9:0]  o_efficiency_score,
    input wire logic [9:0]  o_overall_score,
    input wire logic [2:0]  o_health_level
);

    // Every result strobe traces back to a request a fixed latency earlier. The strobe
    // is sampled at the edge after the one where it rises, hence the extra lookback.
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LATENCY + 1))
        else $error("result strobe without a matching request");

    // All scores stay within 0..1000.
    a_scores_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_score <= SCORE_MAX) && (o_flow_score <= SCORE_MAX)
                 && (o_pressure_score <= SCORE_MAX) && (o_vibration_score <= SCORE_MAX)
                 && (o_water_score <= SCORE_MAX) && (o_efficiency_score <= SCORE_MAX)
                 && (o_overall_score <= SCORE_MAX))
        else $error("score out of range");

    // Level agrees with the total at the top band.
    a_level_excellent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_overall_score >= 10'd900)) |-> (o_health_level == LEVEL_EXCELLENT))
        else $error("total of 900 or more not classed excellent");

    // Level agrees with the total at the bottom band.
    a_level_danger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_overall_score < 10'd300)) |-> (o_health_level == LEVEL_DANGER))
        else $error("total below 300 not classed danger");

endmodule

bind cooling_health_scorer_core chs_checker u_chs_checker (.*);

`default_nettype wire

// ===== sim/tb_cooling_health_scorer_core.sv =====
// Self-checking testbench for cooling_health_scorer_core: drives sensor samples and weights,
// predicts every score, the weighted total and the level, and compares each result strobe.
// Depends on chs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_cooling_health_scorer_core;
    import chs_pkg::*;

    // Spare register indexes that the block must ignore.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [11:0] cpu;
        logic signed [11:0] water;
        logic [11:0]        flow;
        logic [9:0]         pressure;
        logic [13:0]        vibration;
        logic [15:0]        solids;
        logic [6:0]         duty;
    } t_sensor_sample;

    typedef struct packed {
        t_score     temperature;
        t_score     flow;
        t_score     pressure;
        t_score     vibration;
        t_score     water;
        t_score     efficiency;
        t_score     total;
        logic [2:0] level;
    } t_health_report;

    // Keeps its own copy of the weights and the reports still owed by the block.
    class grade_scoreboard;
        t_weight_vec    weights;
        t_health_report pending_grades[$];
        int             mismatch_count;

        function new();
            weights        = WEIGHT_RESET;
            mismatch_count = 0;
        endfunction

        function void note_config(logic [2:0] index, logic [6:0] data);
            if (int'(index) < NUM_DIM) begin
                weights[index] = data;
            end
        endfunction

        // Smaller is better, breakpoints p < g < w < b.
        function int fall_score(int v, int p, int g, int w, int b);
            if (v <= p) return 1000;
            if (v <= g) return 800 + 200 * (g - v) / (g - p);
            if (v <= w) return 500 + 300 * (w - v) / (w - g);
            if (v <= b) return 200 + 300 * (b - v) / (b - w);
            if (v < 2 * b) return 200 * (2 * b - v) / b;
            return 0;
        endfunction

        // Larger is better, breakpoints p > g > w > b.
        function int rise_score(int v, int p, int g, int w, int b);
            if (v >= p) return 1000;
            if (v >= g) return 800 + 200 * (v - g) / (p - g);
            if (v >= w) return 500 + 300 * (v - w) / (g - w);
            if (v >= b) return 200 + 300 * (v - b) / (w - b);
            if (v <= 0) return 0;
            return 200 * v / b;
        endfunction

        function t_health_report grade_sample(t_sensor_sample s);
            t_health_report r;
            int             lane_score[NUM_DIM];
            int             cpu;
            int             dev;
            int             gap;
            int             duty;
            int             sum;
            cpu  = int'($signed(s.cpu));
            duty = int'(s.duty);
            lane_score[DIM_TEMP] = fall_score(cpu, 450, 600, 750, 850);
            lane_score[DIM_FLOW] = rise_score(int'(s.flow), 400, 300, 150, 50);
            dev = int'(s.pressure) - 200;
            if (dev < 0) dev = -dev;
            lane_score[DIM_PRES] = fall_score(dev, 20, 50, 100, 150);
            lane_score[DIM_VIB]  = fall_score(int'(s.vibration), 300, 500, 1000, 2000);
            lane_score[DIM_WATR] = fall_score(int'(s.solids), 50, 100, 300, 500);
            // A water side hotter than the CPU counts as no gap at all.
            gap = cpu - int'($signed(s.water));
            if (gap < 0) gap = 0;
            lane_score[DIM_EFF] = fall_score(gap, 100, 150, 250, 350);
            // A slow pump pulls the efficiency score toward full marks.
            if (duty < 50) begin
                lane_score[DIM_EFF] = (lane_score[DIM_EFF] * duty + 1000 * (50 - duty)) / 50;
            end
            sum = 0;
            for (int lane = 0; lane < NUM_DIM; lane++) begin
                sum += lane_score[lane] * int'(weights[lane]);
            end
            sum /= 100;
            if (sum > 1000) sum = 1000;
            r.temperature = t_score'(lane_score[DIM_TEMP]);
            r.flow        = t_score'(lane_score[DIM_FLOW]);
            r.pressure    = t_score'(lane_score[DIM_PRES]);
            r.vibration   = t_score'(lane_score[DIM_VIB]);
            r.water       = t_score'(lane_score[DIM_WATR]);
            r.efficiency  = t_score'(lane_score[DIM_EFF]);
            r.total       = t_score'(sum);
            if (sum >= 900)      r.level = LEVEL_EXCELLENT;
            else if (sum >= 700) r.level = LEVEL_GOOD;
            else if (sum >= 500) r.level = LEVEL_FAIR;
            else if (sum >= 300) r.level = LEVEL_POOR;
            else                 r.level = LEVEL_DANGER;
            return r;
        endfunction

        function void note_sample(t_sensor_sample s);
            pending_grades.push_back(grade_sample(s));
        endfunction

        function void compare_field(string field, logic [9:0] want, logic [9:0] got);
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $realtime, field, want, got);
                end
            end
        endfunction

        function void check_result(t_health_report got);
            t_health_report want;
            if (pending_grades.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result strobe with no request outstanding", $realtime);
                end
                return;
            end
            want = pending_grades.pop_front();
            compare_field("temperature_score", want.temperature, got.temperature);
            compare_field("flow_score", want.flow, got.flow);
            compare_field("pressure_score", want.pressure, got.pressure);
            compare_field("vibration_score", want.vibration, got.vibration);
            compare_field("water_score", want.water, got.water);
            compare_field("efficiency_score", want.efficiency, got.efficiency);
            compare_field("overall_score", want.total, got.total);
            compare_field("health_level", 10'(want.level), 10'(got.level));
        endfunction

        function int pending();
            return pending_grades.size();
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           start     = 1'b0;
    t_sensor_sample sensor    = '0;
    logic           cfg_we    = 1'b0;
    logic [2:0]     cfg_index = '0;
    logic [6:0]     cfg_data  = '0;

    logic           busy;
    logic           valid;
    t_health_report report;
    t_health_report observed;

    grade_scoreboard sb = new();

    cooling_health_scorer_core dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_start             (start),
        .o_busy              (busy),
        .i_cpu_temperature   (sensor.cpu),
        .i_water_temperature (sensor.water),
        .i_flow_rate         (sensor.flow),
        .i_loop_pressure     (sensor.pressure),
        .i_vibration_level   (sensor.vibration),
        .i_dissolved_solids  (sensor.solids),
        .i_pump_duty         (sensor.duty),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_valid             (valid),
        .o_temperature_score (report.temperature),
        .o_flow_score        (report.flow),
        .o_pressure_score    (report.pressure),
        .o_vibration_score   (report.vibration),
        .o_water_score       (report.water),
        .o_efficiency_score  (report.efficiency),
        .o_overall_score     (report.total),
        .o_health_level      (report.level)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Everything is sampled at the edge that accepts it, before this edge's updates land.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                sb.note_config(cfg_index, cfg_data);
            end
            if (start && busy === 1'b0) begin
                sb.note_sample(sensor);
            end
            if (valid === 1'b1) begin
                observed = report;
                sb.check_result(observed);
            end
        end
    end

    // Presents one request and returns at the edge that takes it.
    task automatic issue_request(input t_sensor_sample s);
        start  <= 1'b1;
        sensor <= s;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every outstanding request has produced its result.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Writes all six weights, with junk to the spare indexes first.
    task automatic load_weights(input t_weight_vec w);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_LO;
        cfg_data  <= 7'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data  <= 7'($urandom);
        @(posedge clk);
        for (int lane = 0; lane < NUM_DIM; lane++) begin
            cfg_index <= 3'(lane);
            cfg_data  <= w[lane];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic t_sensor_sample make_sensor(int cpu, int water, int flow, int pressure,
                                                   int vibration, int solids, int duty);
        t_sensor_sample s;
        s.cpu       = 12'(cpu);
        s.water     = 12'(water);
        s.flow      = 12'(flow);
        s.pressure  = 10'(pressure);
        s.vibration = 14'(vibration);
        s.solids    = 16'(solids);
        s.duty      = 7'(duty);
        return s;
    endfunction

    function automatic bit roll_wide();
        return $urandom_range(0, 5) == 0;
    endfunction

    // Mostly realistic readings around the breakpoints, now and then any bit pattern.
    function automatic t_sensor_sample random_sensor();
        t_sensor_sample s;
        int             cpu;
        cpu   = roll_wide() ? int'($urandom_range(0, 4095)) - 2048
                            : int'($urandom_range(0, 1900)) - 400;
        s.cpu = 12'(cpu);
        s.water = roll_wide() ? 12'($urandom)
                              : 12'(cpu - int'($urandom_range(0, 450)) + 50);
        s.flow = roll_wide() ? 12'($urandom)
                             : 12'($urandom_range(0, ($urandom_range(0, 2) == 0) ? 3000 : 450));
        s.pressure  = roll_wide() ? 10'($urandom) : 10'($urandom_range(0, 520));
        s.vibration = roll_wide() ? 14'($urandom) : 14'($urandom_range(0, 4500));
        s.solids    = roll_wide() ? 16'($urandom) : 16'($urandom_range(0, 1100));
        s.duty      = roll_wide() ? 7'($urandom) : 7'($urandom_range(0, 110));
        return s;
    endfunction

    function automatic t_weight_vec random_weights();
        t_weight_vec w;
        for (int lane = 0; lane < NUM_DIM; lane++) begin
            w[lane] = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 40));
        end
        return w;
    endfunction

    // Bursts of back-to-back requests, most of them followed by a random gap.
    task automatic run_random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++) begin
                issue_request(random_sensor());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                hold_off($urandom_range(1, 8));
            end
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and breakpoints under the default weights.
        issue_request(make_sensor(-2048, -2048, 0, 0, 0, 0, 0));
        issue_request(make_sensor(2047, 2047, 4095, 1023, 16383, 65535, 127));
        issue_request(make_sensor(450, 350, 400, 220, 300, 50, 50));
        issue_request(make_sensor(451, 300, 399, 221, 301, 51, 49));
        issue_request(make_sensor(600, 450, 300, 250, 500, 100, 100));
        issue_request(make_sensor(750, 500, 150, 300, 1000, 300, 75));
        issue_request(make_sensor(850, 500, 50, 350, 2000, 500, 60));
        issue_request(make_sensor(851, 0, 49, 351, 2001, 501, 25));
        issue_request(make_sensor(1699, -400, 1, 50, 3999, 999, 1));
        issue_request(make_sensor(1700, -400, 4095, 49, 4000, 1000, 127));
        // Water hotter than the CPU, with and without the pump blend.
        issue_request(make_sensor(-400, 1500, 3000, 1000, 16000, 65535, 100));
        issue_request(make_sensor(500, 600, 200, 199, 700, 75, 0));
        // Duty above 100 behaves like any duty of 50 or more.
        issue_request(make_sensor(1000, -2048, 2000, 200, 1500, 400, 101));
        issue_request(make_sensor(650, 620, 350, 160, 400, 60, 49));
        issue_request(make_sensor(-1, 0, 2048, 512, 8192, 32768, 64));
        issue_request(make_sensor(1500, 1000, 100, 150, 2500, 200, 50));
        issue_request(make_sensor(1024, 512, 1024, 700, 1234, 4321, 33));
        issue_request(make_sensor(300, 200, 500, 180, 250, 40, 90));
        wait_for_drain();

        run_random_phase(100);

        // All weights zero, then all at the field maximum so the total clamps.
        load_weights('0);
        run_random_phase(60);
        load_weights({NUM_DIM{7'h7f}});
        run_random_phase(60);

        // One lane carries the whole weight.
        load_weights({7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd100});
        run_random_phase(60);

        for (int phase = 0; phase < 5; phase++) begin
            load_weights(random_weights());
            run_random_phase(70);
        end

        // Back to the default weights for the last stretch.
        load_weights(WEIGHT_RESET);
        run_random_phase(100);

        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
